FILE: src/i2cm_pkg.sv
// Package for the I2C register-access master.
// Types, codes and defaults shared by the interfaces, the pipeline stages and the top level.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned MaxLengthDef    = 256;
  localparam int unsigned RecoverClocksDef = 9;
  localparam int unsigned LenW            = 9;
  localparam int unsigned PhW             = 26;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_PROBE   = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_RECOVER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NACK     = 2'd1,
    STS_ZERO_LEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FR_ADDR_W = 2'd0,
    FR_REG    = 2'd1,
    FR_ADDR_R = 2'd2,
    FR_DATA   = 2'd3
  } frame_e;

  typedef enum logic [PhW-1:0] {
    PH_IDLE     = 26'h0000001,
    PH_ST_SDA_H = 26'h0000002,
    PH_ST_SCL_H = 26'h0000004,
    PH_ST_SDA_L = 26'h0000008,
    PH_ST_SCL_L = 26'h0000010,
    PH_WB_SDA   = 26'h0000020,
    PH_WB_SCL_H = 26'h0000040,
    PH_WB_SCL_L = 26'h0000080,
    PH_WA_SDA   = 26'h0000100,
    PH_WA_SCL_H = 26'h0000200,
    PH_WA_SCL_L = 26'h0000400,
    PH_WD_WAIT  = 26'h0000800,
    PH_RB_SDA   = 26'h0001000,
    PH_RB_SCL_H = 26'h0002000,
    PH_RB_SCL_L = 26'h0004000,
    PH_RA_SDA   = 26'h0008000,
    PH_RA_SCL_H = 26'h0010000,
    PH_RA_SCL_L = 26'h0020000,
    PH_RA_REL   = 26'h0040000,
    PH_RC_SCL_H = 26'h0080000,
    PH_RC_SDA_H = 26'h0100000,
    PH_RC_CLK_H = 26'h0200000,
    PH_RC_CLK_L = 26'h0400000,
    PH_SP_SDA_L = 26'h0800000,
    PH_SP_SCL_H = 26'h1000000,
    PH_SP_SDA_H = 26'h2000000
  } phase_e;

  // start, write-byte, write-ack and data-wait phases
  localparam logic [PhW-1:0] WrPhaseMask = 26'h0000FFE;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      op;
    logic [6:0]      addr7;
    logic [7:0]      reg_req;
    logic [LenW-1:0] length;
    logic [7:0]      data_byte;
    logic            sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       want_data;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

endpackage

FILE: src/i2cm_if.sv
// Valid/ready channel interfaces for the command/tick input and the result output.
// Depends on i2cm_pkg.
interface i2cm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [1:0]                    op;
  logic [6:0]                    addr7;
  logic [7:0]                    reg_req;
  logic [i2cm_pkg::LenW-1:0]     length;
  logic [7:0]                    data_byte;
  logic                          sda_in;

  modport source (output valid, kind, op, addr7, reg_req, length, data_byte, sda_in,
                  input ready);
  modport sink (input valid, kind, op, addr7, reg_req, length, data_byte, sda_in,
                output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       want_data;
  logic       rd_valid;
  logic [7:0] rd_data;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_out, sda_out, busy_res, want_data, rd_valid, rd_data,
                  done_res, status, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, want_data, rd_valid, rd_data,
                done_res, status, output ready);
endinterface

FILE: src/i2cm_in_stage.sv
// Input register: captures one transfer from the input channel.
// Depends on i2cm_pkg and i2cm_in_if.
module i2cm_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2cm_in_if.sink            in_i,
  input  logic               adv_i,
  output logic               valid_o,
  output i2cm_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  i2cm_pkg::in_item_t item_q, item_d;
  logic               take;

  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d = 1'b1;
      item_d  = '{kind: in_i.kind, op: in_i.op, addr7: in_i.addr7, reg_req: in_i.reg_req,
                  length: in_i.length, data_byte: in_i.data_byte, sda_in: in_i.sda_in};
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/i2cm_fsm.sv
// Bus sequencer: applies one item per step to the I2C phase state and forms its result.
// Depends on i2cm_pkg.
module i2cm_fsm #(
  parameter int unsigned MAX_LENGTH     = i2cm_pkg::MaxLengthDef,
  parameter int unsigned RECOVER_CLOCKS = i2cm_pkg::RecoverClocksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cm_pkg::in_item_t  item_i,
  output i2cm_pkg::out_item_t res_o
);

  localparam int unsigned LenW = i2cm_pkg::LenW;
  localparam logic [16:0] MaxLenV  = 17'(MAX_LENGTH);
  localparam logic [LenW-1:0] RecClk = LenW'(RECOVER_CLOCKS);

  i2cm_pkg::phase_e  phase_q, phase_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [LenW-1:0]   byte_cnt_q, byte_cnt_d;
  i2cm_pkg::op_e     cmd_op_q, cmd_op_d;
  logic [6:0]        cmd_addr_q, cmd_addr_d;
  logic [7:0]        cmd_reg_q, cmd_reg_d;
  logic [LenW-1:0]   cmd_len_q, cmd_len_d;
  logic [7:0]        hold_q, hold_d;
  logic              hold_full_q, hold_full_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  i2cm_pkg::frame_e  frame_q, frame_d;
  i2cm_pkg::status_e pend_q, pend_d;
  logic              nack_q, nack_d;

  logic              rd_valid;
  logic [7:0]        rd_data;
  logic              done;
  logic [1:0]        status;
  logic [LenW-1:0]   len_sat;
  logic [3:0]        bit_inc;
  logic [7:0]        shift_in;
  logic [LenW-1:0]   byte_inc;
  logic              want;

  assign len_sat  = ({8'b0, item_i.length} > MaxLenV) ? MaxLenV[LenW-1:0] : item_i.length;
  assign bit_inc  = bit_cnt_q + 4'd1;
  assign shift_in = {shift_q[6:0], item_i.sda_in};
  assign byte_inc = byte_cnt_q + LenW'(1);

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    byte_cnt_d  = byte_cnt_q;
    cmd_op_d    = cmd_op_q;
    cmd_addr_d  = cmd_addr_q;
    cmd_reg_d   = cmd_reg_q;
    cmd_len_d   = cmd_len_q;
    hold_d      = hold_q;
    hold_full_d = hold_full_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    frame_d     = frame_q;
    pend_d      = pend_q;
    nack_d      = nack_q;
    rd_valid    = 1'b0;
    rd_data     = 8'd0;
    done        = 1'b0;
    status      = i2cm_pkg::STS_OK;

    case (item_i.kind)
      i2cm_pkg::KIND_CMD: begin
        if (phase_q == i2cm_pkg::PH_IDLE) begin
          cmd_op_d    = i2cm_pkg::op_e'(item_i.op);
          cmd_addr_d  = item_i.addr7;
          cmd_reg_d   = item_i.reg_req;
          cmd_len_d   = len_sat;
          hold_full_d = 1'b0;
          byte_cnt_d  = '0;
          bit_cnt_d   = 4'd0;
          frame_d     = i2cm_pkg::FR_ADDR_W;
          pend_d      = i2cm_pkg::STS_OK;
          if (item_i.op == i2cm_pkg::OP_RECOVER) begin
            phase_d = i2cm_pkg::PH_RC_SCL_H;
          end else if (item_i.op == i2cm_pkg::OP_READ && len_sat == '0) begin
            done   = 1'b1;
            status = i2cm_pkg::STS_ZERO_LEN;
          end else begin
            phase_d = i2cm_pkg::PH_ST_SDA_H;
          end
        end
      end
      i2cm_pkg::KIND_DATA: begin
        hold_d      = item_i.data_byte;
        hold_full_d = 1'b1;
      end
      i2cm_pkg::KIND_TICK: begin
        unique case (phase_q)
          i2cm_pkg::PH_ST_SDA_H: begin
            sda_d = 1'b1; phase_d = i2cm_pkg::PH_ST_SCL_H;
          end
          i2cm_pkg::PH_ST_SCL_H: begin
            scl_d = 1'b1; phase_d = i2cm_pkg::PH_ST_SDA_L;
          end
          i2cm_pkg::PH_ST_SDA_L: begin
            sda_d = 1'b0; phase_d = i2cm_pkg::PH_ST_SCL_L;
          end
          i2cm_pkg::PH_ST_SCL_L: begin
            scl_d = 1'b0;
            if (cmd_op_q == i2cm_pkg::OP_WRITE && cmd_len_q == '0) begin
              pend_d  = i2cm_pkg::STS_ZERO_LEN;
              phase_d = i2cm_pkg::PH_SP_SDA_L;
            end else begin
              case (frame_q)
                i2cm_pkg::FR_REG:    shift_d = cmd_reg_q;
                i2cm_pkg::FR_ADDR_R: shift_d = {cmd_addr_q, 1'b1};
                default:             shift_d = {cmd_addr_q, 1'b0};
              endcase
              bit_cnt_d = 4'd0;
              phase_d   = i2cm_pkg::PH_WB_SDA;
            end
          end
          i2cm_pkg::PH_WB_SDA: begin
            sda_d = shift_q[7]; phase_d = i2cm_pkg::PH_WB_SCL_H;
          end
          i2cm_pkg::PH_WB_SCL_H: begin
            scl_d = 1'b1; phase_d = i2cm_pkg::PH_WB_SCL_L;
          end
          i2cm_pkg::PH_WB_SCL_L: begin
            scl_d     = 1'b0;
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = bit_inc;
            phase_d   = (bit_inc >= 4'd8) ? i2cm_pkg::PH_WA_SDA : i2cm_pkg::PH_WB_SDA;
          end
          i2cm_pkg::PH_WA_SDA: begin
            sda_d = 1'b1; phase_d = i2cm_pkg::PH_WA_SCL_H;
          end
          i2cm_pkg::PH_WA_SCL_H: begin
            scl_d   = 1'b1;
            nack_d  = item_i.sda_in;
            phase_d = i2cm_pkg::PH_WA_SCL_L;
          end
          i2cm_pkg::PH_WA_SCL_L: begin
            scl_d = 1'b0;
            if (nack_q) begin
              pend_d  = i2cm_pkg::STS_NACK;
              phase_d = i2cm_pkg::PH_SP_SDA_L;
            end else if (cmd_op_q == i2cm_pkg::OP_PROBE) begin
              pend_d  = i2cm_pkg::STS_OK;
              phase_d = i2cm_pkg::PH_SP_SDA_L;
            end else if (frame_q == i2cm_pkg::FR_ADDR_W) begin
              frame_d   = i2cm_pkg::FR_REG;
              shift_d   = cmd_reg_q;
              bit_cnt_d = 4'd0;
              phase_d   = i2cm_pkg::PH_WB_SDA;
            end else if (frame_q == i2cm_pkg::FR_REG && cmd_op_q == i2cm_pkg::OP_READ) begin
              frame_d = i2cm_pkg::FR_ADDR_R;
              phase_d = i2cm_pkg::PH_ST_SDA_H;
            end else if (frame_q == i2cm_pkg::FR_ADDR_R) begin
              phase_d = i2cm_pkg::PH_RB_SDA;
            end else begin
              frame_d = i2cm_pkg::FR_DATA;
              if (byte_cnt_q >= cmd_len_q) begin
                pend_d  = i2cm_pkg::STS_OK;
                phase_d = i2cm_pkg::PH_SP_SDA_L;
              end else begin
                phase_d = i2cm_pkg::PH_WD_WAIT;
              end
            end
          end
          i2cm_pkg::PH_WD_WAIT: begin
            if (hold_full_q) begin
              hold_full_d = 1'b0;
              byte_cnt_d  = byte_inc;
              shift_d     = hold_q;
              bit_cnt_d   = 4'd0;
              sda_d       = hold_q[7];
              phase_d     = i2cm_pkg::PH_WB_SCL_H;
            end
          end
          i2cm_pkg::PH_RB_SDA: begin
            sda_d     = 1'b1;
            bit_cnt_d = 4'd0;
            shift_d   = 8'd0;
            phase_d   = i2cm_pkg::PH_RB_SCL_H;
          end
          i2cm_pkg::PH_RB_SCL_H: begin
            scl_d     = 1'b1;
            shift_d   = shift_in;
            bit_cnt_d = bit_inc;
            if (bit_inc >= 4'd8) begin
              rd_valid = 1'b1;
              rd_data  = shift_in;
            end
            phase_d = i2cm_pkg::PH_RB_SCL_L;
          end
          i2cm_pkg::PH_RB_SCL_L: begin
            scl_d   = 1'b0;
            phase_d = (bit_cnt_q >= 4'd8) ? i2cm_pkg::PH_RA_SDA : i2cm_pkg::PH_RB_SCL_H;
          end
          i2cm_pkg::PH_RA_SDA: begin
            // ACK all but the last byte
            sda_d   = ({1'b0, byte_cnt_q} + (LenW+1)'(1) < {1'b0, cmd_len_q}) ? 1'b0 : 1'b1;
            phase_d = i2cm_pkg::PH_RA_SCL_H;
          end
          i2cm_pkg::PH_RA_SCL_H: begin
            scl_d = 1'b1; phase_d = i2cm_pkg::PH_RA_SCL_L;
          end
          i2cm_pkg::PH_RA_SCL_L: begin
            scl_d = 1'b0; phase_d = i2cm_pkg::PH_RA_REL;
          end
          i2cm_pkg::PH_RA_REL: begin
            sda_d      = 1'b1;
            byte_cnt_d = byte_inc;
            if (byte_inc < cmd_len_q) begin
              phase_d = i2cm_pkg::PH_RB_SDA;
            end else begin
              pend_d  = i2cm_pkg::STS_OK;
              phase_d = i2cm_pkg::PH_SP_SDA_L;
            end
          end
          i2cm_pkg::PH_RC_SCL_H: begin
            scl_d = 1'b1; phase_d = i2cm_pkg::PH_RC_SDA_H;
          end
          i2cm_pkg::PH_RC_SDA_H: begin
            sda_d      = 1'b1;
            byte_cnt_d = '0;
            phase_d    = i2cm_pkg::PH_RC_CLK_H;
          end
          i2cm_pkg::PH_RC_CLK_H: begin
            scl_d = 1'b1; phase_d = i2cm_pkg::PH_RC_CLK_L;
          end
          i2cm_pkg::PH_RC_CLK_L: begin
            scl_d      = 1'b0;
            byte_cnt_d = byte_inc;
            if (byte_inc >= RecClk) begin
              pend_d  = i2cm_pkg::STS_OK;
              phase_d = i2cm_pkg::PH_SP_SDA_L;
            end else begin
              phase_d = i2cm_pkg::PH_RC_CLK_H;
            end
          end
          i2cm_pkg::PH_SP_SDA_L: begin
            sda_d = 1'b0; phase_d = i2cm_pkg::PH_SP_SCL_H;
          end
          i2cm_pkg::PH_SP_SCL_H: begin
            scl_d = 1'b1; phase_d = i2cm_pkg::PH_SP_SDA_H;
          end
          i2cm_pkg::PH_SP_SDA_H: begin
            sda_d   = 1'b1;
            done    = 1'b1;
            status  = pend_q;
            phase_d = i2cm_pkg::PH_IDLE;
          end
          default: begin
            phase_d = i2cm_pkg::PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign want = ((phase_d & i2cm_pkg::WrPhaseMask) != '0) &&
                cmd_op_d == i2cm_pkg::OP_WRITE && !hold_full_d && byte_cnt_d < cmd_len_d;

  assign res_o = '{scl_out: scl_d, sda_out: sda_d, busy_res: phase_d != i2cm_pkg::PH_IDLE,
                   want_data: want, rd_valid: rd_valid, rd_data: rd_data, done_res: done,
                   status: status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cm_pkg::PH_IDLE;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      byte_cnt_q  <= '0;
      cmd_op_q    <= i2cm_pkg::OP_PROBE;
      cmd_addr_q  <= 7'd0;
      cmd_reg_q   <= 8'd0;
      cmd_len_q   <= '0;
      hold_q      <= 8'd0;
      hold_full_q <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      frame_q     <= i2cm_pkg::FR_ADDR_W;
      pend_q      <= i2cm_pkg::STS_OK;
      nack_q      <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      byte_cnt_q  <= byte_cnt_d;
      cmd_op_q    <= cmd_op_d;
      cmd_addr_q  <= cmd_addr_d;
      cmd_reg_q   <= cmd_reg_d;
      cmd_len_q   <= cmd_len_d;
      hold_q      <= hold_d;
      hold_full_q <= hold_full_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      frame_q     <= frame_d;
      pend_q      <= pend_d;
      nack_q      <= nack_d;
    end
  end

  // SCL stays low while a write byte is outstanding
  a_wait_scl_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == i2cm_pkg::PH_WD_WAIT |-> !scl_q)
    else $error("SCL released while waiting for write data");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == i2cm_pkg::PH_IDLE)
    else $error("operation finished but sequencer not idle");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == i2cm_pkg::PH_IDLE && item_i.kind == i2cm_pkg::KIND_TICK
    |=> phase_q == i2cm_pkg::PH_IDLE && $stable(scl_q) && $stable(sda_q))
    else $error("idle tick changed bus state");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'd8)
    else $error("bit counter past one byte");

  a_read_ack_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.rd_valid |=> phase_q == i2cm_pkg::PH_RB_SCL_L && bit_cnt_q == 4'd8)
    else $error("read byte reported outside the eighth bit");

endmodule

FILE: src/i2cm_out_stage.sv
// Result register: holds one result until the output channel takes it.
// Depends on i2cm_pkg and i2cm_out_if.
module i2cm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2cm_pkg::out_item_t res_i,
  output logic                adv_o,
  i2cm_out_if.source          out_o
);

  logic                valid_q, valid_d;
  i2cm_pkg::out_item_t res_q;

  assign adv_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.scl_out   = res_q.scl_out;
  assign out_o.sda_out   = res_q.sda_out;
  assign out_o.busy_res  = res_q.busy_res;
  assign out_o.want_data = res_q.want_data;
  assign out_o.rd_valid  = res_q.rd_valid;
  assign out_o.rd_data   = res_q.rd_data;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.status    = res_q.status;

endmodule

FILE: src/i2c_master_register_access.sv
// Top level of the I2C register-access master: input register, bus sequencer, result register.
// Depends on i2cm_pkg, i2cm_if, i2cm_in_stage, i2cm_fsm and i2cm_out_stage.
//
// Each transfer on in_i is a command, a write data byte or a tick that carries the sampled SDA
// level; each gives exactly one transfer on out_o with the open-drain SCL/SDA drive and status.
// A tick moves the bus by one line change, so the caller paces the I2C bit rate by the tick
// rate. The block takes one transfer per clock while out_o does not stall: it passes through
// an input register and the sequencer logic into a result register, and a new item is
// accepted in the same cycle that a waiting result is taken. Lengths above MAX_LENGTH
// are clipped to it; bus recovery gives RECOVER_CLOCKS clock pulses before the stop.
module i2c_master_register_access #(
  parameter int unsigned MAX_LENGTH     = i2cm_pkg::MaxLengthDef,
  parameter int unsigned RECOVER_CLOCKS = i2cm_pkg::RecoverClocksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_in_if.sink    in_i,
  i2cm_out_if.source out_o
);

  logic                item_valid;
  logic                adv;
  logic                step;
  i2cm_pkg::in_item_t  item;
  i2cm_pkg::out_item_t res;

  assign step = item_valid && adv;

  i2cm_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (item_valid),
    .item_o  (item)
  );

  i2cm_fsm #(
    .MAX_LENGTH     (MAX_LENGTH),
    .RECOVER_CLOCKS (RECOVER_CLOCKS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  i2cm_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .res_i  (res),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for i2c_master_register_access: directed and random command/tick/data transfers,
// each result checked against a cycle-free predictor of the bus sequencer.
// Depends on i2cm_pkg, i2cm_if and the RTL of the block.
module tb_top;

  localparam logic [1:0] KindSpare  = 2'd3;
  localparam int         RandItems  = 500;
  localparam int         CycleLimit = 400000;
  localparam int         MaxReports = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2cm_in_if  cmd_if ();
  i2cm_out_if res_if ();

  i2c_master_register_access u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  i2cm_pkg::phase_e  m_phase;
  logic [3:0]        m_bits;
  logic [7:0]        m_shift;
  logic [8:0]        m_bytes;
  i2cm_pkg::op_e     m_op;
  logic [6:0]        m_addr;
  logic [7:0]        m_reg;
  logic [8:0]        m_len;
  logic [7:0]        m_hold;
  logic              m_hold_full;
  logic              m_scl;
  logic              m_sda;
  i2cm_pkg::frame_e  m_frame;
  i2cm_pkg::status_e m_pend;
  logic              m_nack;

  i2cm_pkg::out_item_t bus_result_q[$];
  int        errors      = 0;
  int        work_items  = 0;
  int        src_idle_pct  = 22;
  int        sink_idle_pct = 22;

  function automatic logic [7:0] frame_byte();
    case (m_frame)
      i2cm_pkg::FR_REG:    return m_reg;
      i2cm_pkg::FR_ADDR_R: return {m_addr, 1'b1};
      default:             return {m_addr, 1'b0};
    endcase
  endfunction

  function automatic void start_stop(i2cm_pkg::status_e st);
    m_pend  = st;
    m_phase = i2cm_pkg::PH_SP_SDA_L;
  endfunction

  function automatic i2cm_pkg::out_item_t bus_step(i2cm_pkg::in_item_t it);
    i2cm_pkg::out_item_t r;
    logic [8:0] len;
    r = '0;
    if (it.kind == i2cm_pkg::KIND_CMD) begin
      if (m_phase == i2cm_pkg::PH_IDLE) begin
        len = (it.length > i2cm_pkg::MaxLengthDef) ? 9'(i2cm_pkg::MaxLengthDef) : it.length;
        m_op        = i2cm_pkg::op_e'(it.op);
        m_addr      = it.addr7;
        m_reg       = it.reg_req;
        m_len       = len;
        m_hold_full = 1'b0;
        m_bytes     = '0;
        m_bits      = '0;
        m_frame     = i2cm_pkg::FR_ADDR_W;
        m_pend      = i2cm_pkg::STS_OK;
        if (m_op == i2cm_pkg::OP_RECOVER) begin
          m_phase = i2cm_pkg::PH_RC_SCL_H;
        end else if (m_op == i2cm_pkg::OP_READ && len == 0) begin
          r.done_res = 1'b1;
          r.status   = i2cm_pkg::STS_ZERO_LEN;
        end else begin
          m_phase = i2cm_pkg::PH_ST_SDA_H;
        end
      end
    end else if (it.kind == i2cm_pkg::KIND_DATA) begin
      m_hold      = it.data_byte;
      m_hold_full = 1'b1;
    end else if (it.kind == i2cm_pkg::KIND_TICK) begin
      case (m_phase)
        i2cm_pkg::PH_ST_SDA_H: begin m_sda = 1'b1; m_phase = i2cm_pkg::PH_ST_SCL_H; end
        i2cm_pkg::PH_ST_SCL_H: begin m_scl = 1'b1; m_phase = i2cm_pkg::PH_ST_SDA_L; end
        i2cm_pkg::PH_ST_SDA_L: begin m_sda = 1'b0; m_phase = i2cm_pkg::PH_ST_SCL_L; end
        i2cm_pkg::PH_ST_SCL_L: begin
          m_scl = 1'b0;
          if (m_op == i2cm_pkg::OP_WRITE && m_len == 0) begin
            start_stop(i2cm_pkg::STS_ZERO_LEN);
          end else begin
            m_shift = frame_byte();
            m_bits  = '0;
            m_phase = i2cm_pkg::PH_WB_SDA;
          end
        end
        i2cm_pkg::PH_WB_SDA: begin m_sda = m_shift[7]; m_phase = i2cm_pkg::PH_WB_SCL_H; end
        i2cm_pkg::PH_WB_SCL_H: begin m_scl = 1'b1; m_phase = i2cm_pkg::PH_WB_SCL_L; end
        i2cm_pkg::PH_WB_SCL_L: begin
          m_scl   = 1'b0;
          m_shift = {m_shift[6:0], 1'b0};
          m_bits  = m_bits + 1'b1;
          m_phase = (m_bits >= 8) ? i2cm_pkg::PH_WA_SDA : i2cm_pkg::PH_WB_SDA;
        end
        i2cm_pkg::PH_WA_SDA: begin m_sda = 1'b1; m_phase = i2cm_pkg::PH_WA_SCL_H; end
        i2cm_pkg::PH_WA_SCL_H: begin
          m_scl   = 1'b1;
          m_nack  = it.sda_in;
          m_phase = i2cm_pkg::PH_WA_SCL_L;
        end
        i2cm_pkg::PH_WA_SCL_L: begin
          m_scl = 1'b0;
          if (m_nack) begin
            start_stop(i2cm_pkg::STS_NACK);
          end else if (m_op == i2cm_pkg::OP_PROBE) begin
            start_stop(i2cm_pkg::STS_OK);
          end else if (m_frame == i2cm_pkg::FR_ADDR_W) begin
            m_frame = i2cm_pkg::FR_REG;
            m_shift = frame_byte();
            m_bits  = '0;
            m_phase = i2cm_pkg::PH_WB_SDA;
          end else if (m_frame == i2cm_pkg::FR_REG && m_op == i2cm_pkg::OP_READ) begin
            m_frame = i2cm_pkg::FR_ADDR_R;
            m_phase = i2cm_pkg::PH_ST_SDA_H;
          end else if (m_frame == i2cm_pkg::FR_ADDR_R) begin
            m_phase = i2cm_pkg::PH_RB_SDA;
          end else begin
            m_frame = i2cm_pkg::FR_DATA;
            if (m_bytes >= m_len) start_stop(i2cm_pkg::STS_OK);
            else m_phase = i2cm_pkg::PH_WD_WAIT;
          end
        end
        i2cm_pkg::PH_WD_WAIT: begin
          if (m_hold_full) begin
            m_hold_full = 1'b0;
            m_bytes     = m_bytes + 1'b1;
            m_shift     = m_hold;
            m_bits      = '0;
            m_sda       = m_hold[7];
            m_phase     = i2cm_pkg::PH_WB_SCL_H;
          end
        end
        i2cm_pkg::PH_RB_SDA: begin
          m_sda   = 1'b1;
          m_bits  = '0;
          m_shift = '0;
          m_phase = i2cm_pkg::PH_RB_SCL_H;
        end
        i2cm_pkg::PH_RB_SCL_H: begin
          m_scl   = 1'b1;
          m_shift = {m_shift[6:0], it.sda_in};
          m_bits  = m_bits + 1'b1;
          if (m_bits >= 8) begin
            r.rd_valid = 1'b1;
            r.rd_data  = m_shift;
          end
          m_phase = i2cm_pkg::PH_RB_SCL_L;
        end
        i2cm_pkg::PH_RB_SCL_L: begin
          m_scl   = 1'b0;
          m_phase = (m_bits >= 8) ? i2cm_pkg::PH_RA_SDA : i2cm_pkg::PH_RB_SCL_H;
        end
        i2cm_pkg::PH_RA_SDA: begin
          m_sda   = (int'(m_bytes) + 1 < int'(m_len)) ? 1'b0 : 1'b1;
          m_phase = i2cm_pkg::PH_RA_SCL_H;
        end
        i2cm_pkg::PH_RA_SCL_H: begin m_scl = 1'b1; m_phase = i2cm_pkg::PH_RA_SCL_L; end
        i2cm_pkg::PH_RA_SCL_L: begin m_scl = 1'b0; m_phase = i2cm_pkg::PH_RA_REL; end
        i2cm_pkg::PH_RA_REL: begin
          m_sda   = 1'b1;
          m_bytes = m_bytes + 1'b1;
          if (m_bytes < m_len) m_phase = i2cm_pkg::PH_RB_SDA;
          else start_stop(i2cm_pkg::STS_OK);
        end
        i2cm_pkg::PH_RC_SCL_H: begin m_scl = 1'b1; m_phase = i2cm_pkg::PH_RC_SDA_H; end
        i2cm_pkg::PH_RC_SDA_H: begin
          m_sda   = 1'b1;
          m_bytes = '0;
          m_phase = i2cm_pkg::PH_RC_CLK_H;
        end
        i2cm_pkg::PH_RC_CLK_H: begin m_scl = 1'b1; m_phase = i2cm_pkg::PH_RC_CLK_L; end
        i2cm_pkg::PH_RC_CLK_L: begin
          m_scl   = 1'b0;
          m_bytes = m_bytes + 1'b1;
          if (m_bytes >= i2cm_pkg::RecoverClocksDef) start_stop(i2cm_pkg::STS_OK);
          else m_phase = i2cm_pkg::PH_RC_CLK_H;
        end
        i2cm_pkg::PH_SP_SDA_L: begin m_sda = 1'b0; m_phase = i2cm_pkg::PH_SP_SCL_H; end
        i2cm_pkg::PH_SP_SCL_H: begin m_scl = 1'b1; m_phase = i2cm_pkg::PH_SP_SDA_H; end
        i2cm_pkg::PH_SP_SDA_H: begin
          m_sda      = 1'b1;
          r.done_res = 1'b1;
          r.status   = m_pend;
          m_phase    = i2cm_pkg::PH_IDLE;
        end
        default: m_phase = i2cm_pkg::PH_IDLE;
      endcase
    end
    r.scl_out   = m_scl;
    r.sda_out   = m_sda;
    r.busy_res  = (m_phase != i2cm_pkg::PH_IDLE);
    r.want_data = (m_phase != i2cm_pkg::PH_IDLE && m_phase < i2cm_pkg::PH_RB_SDA &&
                   m_op == i2cm_pkg::OP_WRITE && !m_hold_full && m_bytes < m_len);
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (errors < MaxReports)
        $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result check first, then predict the transfer accepted at this edge
  always @(posedge clk_i) begin : check_proc
    i2cm_pkg::out_item_t got;
    i2cm_pkg::out_item_t want;
    i2cm_pkg::in_item_t  acc;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = {res_if.scl_out, res_if.sda_out, res_if.busy_res, res_if.want_data,
               res_if.rd_valid, res_if.rd_data, res_if.done_res, res_if.status};
        if (bus_result_q.size() == 0) begin
          if (errors < MaxReports)
            $display("%0t ns: result expected none actual %p", $time, got);
          errors++;
        end else begin
          want = bus_result_q.pop_front();
          cmp_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
          cmp_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
          cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          cmp_field("want_data", 8'(want.want_data), 8'(got.want_data));
          cmp_field("rd_valid", 8'(want.rd_valid), 8'(got.rd_valid));
          cmp_field("rd_data", want.rd_data, got.rd_data);
          cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
          cmp_field("status", 8'(want.status), 8'(got.status));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        acc = {cmd_if.kind, cmd_if.op, cmd_if.addr7, cmd_if.reg_req, cmd_if.length,
               cmd_if.data_byte, cmd_if.sda_in};
        bus_result_q.push_back(bus_step(acc));
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("i2c_master_register_access: mismatch");
    $finish;
  end

  function automatic i2cm_pkg::in_item_t rand_item();
    i2cm_pkg::in_item_t it;
    it.kind      = 2'($urandom_range(3));
    it.op        = 2'($urandom_range(3));
    it.addr7     = 7'($urandom_range(127));
    it.reg_req   = 8'($urandom_range(255));
    it.length    = 9'($urandom_range(511));
    it.data_byte = 8'($urandom_range(255));
    it.sda_in    = 1'($urandom_range(1));
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(i2cm_pkg::in_item_t it);
    if (m_phase != i2cm_pkg::PH_IDLE || it.kind == i2cm_pkg::KIND_CMD ||
        it.kind == i2cm_pkg::KIND_DATA) work_items++;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid     = 1'b1;
    cmd_if.kind      = it.kind;
    cmd_if.op        = it.op;
    cmd_if.addr7     = it.addr7;
    cmd_if.reg_req   = it.reg_req;
    cmd_if.length    = it.length;
    cmd_if.data_byte = it.data_byte;
    cmd_if.sda_in    = it.sda_in;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  task automatic tick(logic sda);
    i2cm_pkg::in_item_t it;
    it        = rand_item();
    it.kind   = i2cm_pkg::KIND_TICK;
    it.sda_in = sda;
    send_item(it);
  endtask

  task automatic load_byte(logic [7:0] b);
    i2cm_pkg::in_item_t it;
    it           = rand_item();
    it.kind      = i2cm_pkg::KIND_DATA;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic command(i2cm_pkg::op_e op, logic [6:0] addr, logic [7:0] rg,
                         logic [8:0] len);
    i2cm_pkg::in_item_t it;
    it         = rand_item();
    it.kind    = i2cm_pkg::KIND_CMD;
    it.op      = op;
    it.addr7   = addr;
    it.reg_req = rg;
    it.length  = len;
    send_item(it);
  endtask

  // plays the target until the bus is idle; rd_bit 2 gives random read data
  task automatic finish_op(int nack_pct, int noise_pct, int rd_bit);
    while (m_phase != i2cm_pkg::PH_IDLE) begin
      if ($urandom_range(99) < noise_pct)
        send_item(rand_item());
      else if (m_phase == i2cm_pkg::PH_WD_WAIT && !m_hold_full && $urandom_range(3) != 0)
        load_byte(8'($urandom_range(255)));
      else if (m_phase == i2cm_pkg::PH_WA_SCL_H)
        tick($urandom_range(99) < nack_pct);
      else
        tick((rd_bit == 2) ? 1'($urandom_range(1)) : 1'(rd_bit));
    end
  endtask

  task automatic run_op(i2cm_pkg::op_e op, logic [6:0] addr, logic [7:0] rg,
                        logic [8:0] len, int nack_pct, int noise_pct);
    command(op, addr, rg, len);
    finish_op(nack_pct, noise_pct, 2);
  endtask

  task automatic drain();
    cmd_if.valid = 1'b0;
    while (bus_result_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_idle_lines();
    i2cm_pkg::in_item_t it;
    tick(1'b0);
    tick(1'b1);
    load_byte(8'hA5);
    it      = rand_item();
    it.kind = KindSpare;
    send_item(it);
  endtask

  task automatic test_probe();
    run_op(i2cm_pkg::OP_PROBE, 7'h7F, 8'h00, 9'd0, 0, 0);
    run_op(i2cm_pkg::OP_PROBE, 7'h00, 8'hFF, 9'd3, 100, 0);
  endtask

  task automatic test_write();
    load_byte(8'h3C);
    command(i2cm_pkg::OP_WRITE, 7'h55, 8'hFF, 9'd2);
    load_byte(8'h00);
    load_byte(8'hFF);
    finish_op(0, 0, 2);
    run_op(i2cm_pkg::OP_WRITE, 7'h2A, 8'h00, 9'd0, 0, 0);
    run_op(i2cm_pkg::OP_WRITE, 7'h11, 8'h80, 9'd1, 100, 0);
  endtask

  task automatic test_read();
    command(i2cm_pkg::OP_READ, 7'h2A, 8'h10, 9'd2);
    finish_op(0, 0, 1);
    command(i2cm_pkg::OP_READ, 7'h01, 8'h7F, 9'd1);
    finish_op(0, 0, 0);
    run_op(i2cm_pkg::OP_READ, 7'h40, 8'h01, 9'd0, 0, 0);
    drain();
    // length above the maximum, address not acknowledged
    run_op(i2cm_pkg::OP_READ, 7'h33, 8'hC3, 9'd511, 100, 0);
  endtask

  task automatic test_recover();
    command(i2cm_pkg::OP_RECOVER, 7'h00, 8'h00, 9'd0);
    command(i2cm_pkg::OP_READ, 7'h7F, 8'hFF, 9'd256);
    finish_op(0, 0, 2);
  endtask

  task automatic random_round(int nack_pct, int noise_pct);
    int pick;
    int len;
    i2cm_pkg::in_item_t it;
    pick = $urandom_range(99);
    if (pick < 8) begin
      drain();
    end else if (pick < 18) begin
      repeat ($urandom_range(6, 1)) begin
        it = rand_item();
        if (it.kind == i2cm_pkg::KIND_CMD) it.length = 9'($urandom_range(4));
        send_item(it);
      end
      finish_op(nack_pct, noise_pct, 2);
    end else begin
      pick = $urandom_range(99);
      if (pick < 85) len = $urandom_range(4);
      else len = $urandom_range(16, 5);
      if ($urandom_range(3) == 0) load_byte(8'($urandom_range(255)));
      run_op(i2cm_pkg::op_e'($urandom_range(3)), 7'($urandom_range(127)),
             8'($urandom_range(255)), 9'(len), nack_pct, noise_pct);
    end
  endtask

  task automatic test_back_to_back();
    int start;
    start         = work_items;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (work_items - start < 300) random_round(8, 3);
    src_idle_pct  = 22;
    sink_idle_pct = 22;
  endtask

  task automatic test_random();
    int start;
    start = work_items;
    while (work_items - start < RandItems) random_round(8, 5);
  endtask

  initial begin
    m_phase     = i2cm_pkg::PH_IDLE;
    m_bits      = '0;
    m_shift     = '0;
    m_bytes     = '0;
    m_op        = i2cm_pkg::OP_PROBE;
    m_addr      = '0;
    m_reg       = '0;
    m_len       = '0;
    m_hold      = '0;
    m_hold_full = 1'b0;
    m_scl       = 1'b1;
    m_sda       = 1'b1;
    m_frame     = i2cm_pkg::FR_ADDR_W;
    m_pend      = i2cm_pkg::STS_OK;
    m_nack      = 1'b0;

    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.kind      = i2cm_pkg::KIND_TICK;
    cmd_if.op        = i2cm_pkg::OP_PROBE;
    cmd_if.addr7     = '0;
    cmd_if.reg_req   = '0;
    cmd_if.length    = '0;
    cmd_if.data_byte = '0;
    cmd_if.sda_in    = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_lines();
    test_probe();
    test_write();
    test_read();
    test_recover();
    drain();
    test_back_to_back();
    test_random();

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("i2c_master_register_access: match");
    end else begin
      $display("i2c_master_register_access: mismatch");
    end
    $finish;
  end

endmodule
